>>> rtl/core/mtt_pkg.sv
// package: op and result codes, state type, controller/datapath command and status
package mtt_pkg;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_ADD_ONCE   = 3'd1;
    localparam logic [2:0] OP_ADD_PERIOD = 3'd2;
    localparam logic [2:0] OP_CANCEL_ID  = 3'd3;
    localparam logic [2:0] OP_CANCEL_OWN = 3'd4;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_CANCELLED = 3'd1;
    localparam logic [2:0] KIND_FIRED     = 3'd2;
    localparam logic [2:0] KIND_TICK_NONE = 3'd3;
    localparam logic [2:0] KIND_OWN_DONE  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // most fired transfers reported for one tick
    localparam int MAX_RESULTS = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_DONE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_idx;
        logic step;
        logic apply;
        logic emit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic at_end;
        logic is_tick;
        logic single;
        logic capped;
        logic op_valid;
    } t_stat;

endpackage

>>> rtl/core/mtt_ctrl.sv
// controller: sequences one slot per cycle while no fired result waits to be taken, and the result handshake
module mtt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  mtt_pkg::t_stat i_stat,
    output mtt_pkg::t_cmd  o_cmd
);
    import mtt_pkg::*;

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        fire    = i_stat.is_tick && i_stat.hit && !i_stat.capped;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    n_pend        = 1'b0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.op_valid) begin
                    n_state = S_IDLE;
                end else if (fire && r_pend) begin
                    // earlier firing goes out first, it is not the last one
                    n_state = S_EMIT;
                end else begin
                    o_cmd.apply = 1'b1;
                    if (fire) begin
                        o_cmd.emit = 1'b1;
                        n_pend     = 1'b1;
                    end
                    if (i_stat.at_end || (i_stat.hit && i_stat.single)) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> rtl/core/mtt_dp.sv
// datapath: slot table, id counter, per-slot arithmetic and result register
module mtt_dp #(
    parameter int SLOTS      = 16,
    parameter int ID_BITS    = 16,
    parameter int OWNER_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mtt_pkg::t_cmd        i_cmd,
    output mtt_pkg::t_stat       o_stat,
    input  logic [2:0]           i_op,
    input  logic [30:0]          i_delta,
    input  logic signed [31:0]   i_first_delay,
    input  logic signed [31:0]   i_period,
    input  logic [15:0]          i_target_id,
    input  logic [7:0]           i_owner_tag,
    output logic [2:0]           o_kind,
    output logic [1:0]           o_status,
    output logic [15:0]          o_timer_id,
    output logic [7:0]           o_timer_owner,
    output logic                 o_last
);
    import mtt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    logic [SLOTS-1:0]           r_vld;
    logic [SLOTS-1:0]           r_per;
    logic signed [31:0]         r_rem [SLOTS];
    logic signed [31:0]         r_rld [SLOTS];
    logic [ID_BITS-1:0]         r_id  [SLOTS];
    logic [OWNER_BITS-1:0]      r_own [SLOTS];
    logic [ID_BITS-1:0]         r_next_id;

    logic [2:0]                 r_op;
    logic [30:0]                r_delta;
    logic signed [31:0]         r_first, r_period;
    logic [ID_BITS-1:0]         r_tid;
    logic [OWNER_BITS-1:0]      r_otag;
    logic [IW-1:0]              r_idx;
    logic [NW-1:0]              r_nrep;
    logic                       r_found;
    logic [ID_BITS-1:0]         r_hit_id;

    logic                       is_tick, is_add, op_ok, hit, at_end;
    logic signed [32:0]         sub_w, add_w;
    logic signed [31:0]         sub_v, add_v;

    assign is_tick = (r_op == OP_TICK);
    assign is_add  = (r_op == OP_ADD_ONCE) || (r_op == OP_ADD_PERIOD);
    assign op_ok   = is_tick || is_add || (r_op == OP_CANCEL_ID) || (r_op == OP_CANCEL_OWN);
    assign at_end  = (32'(r_idx) == 32'(SLOTS - 1));

    assign sub_w = 33'(r_rem[r_idx]) - 33'($signed({1'b0, r_delta}));
    assign sub_v = (sub_w < -33'sd2147483648) ? 32'sh80000000 : sub_w[31:0];
    assign add_w = 33'(sub_v) + 33'(r_rld[r_idx]);
    assign add_v = (add_w < -33'sd2147483648) ? 32'sh80000000 :
                   (add_w > 33'sd2147483647) ? 32'sh7fffffff : add_w[31:0];

    always_comb begin
        hit = 1'b0;
        case (r_op)
            OP_TICK:       hit = r_vld[r_idx] && (sub_v <= 0);
            OP_ADD_ONCE,
            OP_ADD_PERIOD: hit = !r_vld[r_idx];
            OP_CANCEL_ID:  hit = r_vld[r_idx] && (r_id[r_idx] == r_tid);
            OP_CANCEL_OWN: hit = r_vld[r_idx] && (r_own[r_idx] == r_otag);
            default:       hit = 1'b0;
        endcase
    end

    assign o_stat.hit      = hit;
    assign o_stat.at_end   = at_end;
    assign o_stat.is_tick  = is_tick;
    assign o_stat.single   = is_add || (r_op == OP_CANCEL_ID);
    assign o_stat.capped   = (r_nrep == NW'(MAX_RESULTS));
    assign o_stat.op_valid = op_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_next_id <= '0;
            r_op      <= OP_TICK;
            r_idx     <= '0;
            r_nrep    <= '0;
            r_found   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_op    <= i_op;
                r_nrep  <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.clr_idx) r_idx <= '0;
            if (i_cmd.step)    r_idx <= r_idx + 1'b1;
            if (i_cmd.emit)    r_nrep <= r_nrep + 1'b1;
            // per-slot update while scanning, one slot a cycle unless the scan is held for a result transfer
            if (i_cmd.apply) begin
                case (r_op)
                    OP_TICK: begin
                        if (r_vld[r_idx]) begin
                            if (sub_v > 0) begin
                                r_rem[r_idx] <= sub_v;
                            end else if (r_per[r_idx]) begin
                                r_rem[r_idx] <= add_v;
                            end else begin
                                r_vld[r_idx] <= 1'b0;
                            end
                        end
                    end
                    OP_ADD_ONCE, OP_ADD_PERIOD: begin
                        if (hit) begin
                            r_found        <= 1'b1;
                            r_vld[r_idx]   <= 1'b1;
                            r_per[r_idx]   <= (r_op == OP_ADD_PERIOD);
                            r_rem[r_idx]   <= r_first;
                            r_rld[r_idx]   <= r_period;
                            r_id[r_idx]    <= r_next_id;
                            r_own[r_idx]   <= r_otag;
                            r_hit_id       <= r_next_id;
                            r_next_id      <= r_next_id + 1'b1;
                        end
                    end
                    OP_CANCEL_ID: begin
                        if (hit) begin
                            r_found      <= 1'b1;
                            r_vld[r_idx] <= 1'b0;
                        end
                    end
                    OP_CANCEL_OWN: begin
                        if (hit) r_vld[r_idx] <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_delta  <= i_delta;
            r_first  <= i_first_delay;
            r_period <= (i_op == OP_ADD_PERIOD) ? i_period : 32'sd0;
            r_tid    <= ID_BITS'(i_target_id);
            r_otag   <= OWNER_BITS'(i_owner_tag);
        end
        if (i_cmd.emit) begin
            o_kind        <= KIND_FIRED;
            o_status      <= ST_OK;
            o_timer_id    <= 16'(r_id[r_idx]);
            o_timer_owner <= 8'(r_own[r_idx]);
            o_last        <= 1'b0;
        end else if (i_cmd.finish) begin
            o_last <= 1'b1;
            // a tick that fired keeps its final firing in the register
            if (!(is_tick && r_nrep != '0)) begin
                o_status      <= ST_OK;
                o_timer_id    <= '0;
                o_timer_owner <= '0;
                case (r_op)
                    OP_TICK: o_kind <= KIND_TICK_NONE;
                    OP_ADD_ONCE, OP_ADD_PERIOD: begin
                        o_kind     <= KIND_ADDED;
                        o_status   <= r_found ? ST_OK : ST_FULL;
                        o_timer_id <= r_found ? 16'(r_hit_id) : 16'd0;
                    end
                    OP_CANCEL_ID: begin
                        o_kind     <= KIND_CANCELLED;
                        o_status   <= r_found ? ST_OK : ST_NOT_FOUND;
                        o_timer_id <= 16'(r_tid);
                    end
                    default: o_kind <= KIND_OWN_DONE;
                endcase
            end
        end
    end

endmodule

>>> rtl/core/multi_timer_table_top.sv
// top level: timer bank with one-shot and periodic slots
//  channel | valid   | ready   | payload
//  input   | i_valid | o_ready | i_op i_delta i_first_delay i_period i_target_id i_owner_tag
//  output  | o_valid | i_ready | o_kind o_status o_timer_id o_timer_owner o_last
// an item is taken in idle, then the slots are scanned in turn, then the result is built
// and presented; adds and cancels by id stop at the matching slot, undefined ops
// go back to idle from the scan and give nothing
// each fired timer after the first on a tick waits while the earlier firing is sent out
// reset is synchronous, active low, and frees every slot
// a stalled result holds the scan until the transfer
module multi_timer_table_top #(
    parameter int SLOTS      = 16,
    parameter int ID_BITS    = 16,
    parameter int OWNER_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_op,
    input  logic [30:0]        i_delta,
    input  logic signed [31:0] i_first_delay,
    input  logic signed [31:0] i_period,
    input  logic [15:0]        i_target_id,
    input  logic [7:0]         i_owner_tag,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_kind,
    output logic [1:0]         o_status,
    output logic [15:0]        o_timer_id,
    output logic [7:0]         o_timer_owner,
    output logic               o_last
);
    import mtt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mtt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_stat(stat), .o_cmd(cmd)
    );

    mtt_dp #(.SLOTS(SLOTS), .ID_BITS(ID_BITS), .OWNER_BITS(OWNER_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_op, .i_delta, .i_first_delay, .i_period, .i_target_id, .i_owner_tag,
        .o_kind, .o_status, .o_timer_id, .o_timer_owner, .o_last
    );

endmodule
